// File: design/osa_pkg.sv
`timescale 1ns / 1ps

package osa_pkg;

  localparam int CHAR_W = 8;
  localparam int DIST_OUT_W = 7;
  localparam logic [DIST_OUT_W-1:0] DIST_SAT = 7'd127;

  localparam logic [CHAR_W-1:0] CHAR_UP_A = 8'h41;  // 'A'
  localparam logic [CHAR_W-1:0] CHAR_UP_Z = 8'h5A;  // 'Z'
  localparam logic [CHAR_W-1:0] CHAR_LO_A = 8'h61;  // 'a'

  typedef enum logic [1:0] {
    KIND_FIRST  = 2'd0,
    KIND_SECOND = 2'd1,
    KIND_END    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // control that rides along with the wavefront from cell to cell
  typedef struct packed {
    logic valid;
    logic later_row;
  } link_ctl_t;

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) r = c - CHAR_UP_A + CHAR_LO_A;
    return r;
  endfunction

endpackage

// File: design/osa_edit_distance_top.sv
`timescale 1ns / 1ps
// optimal string alignment distance between two byte strings
// input: a beat is taken when start is high and busy is low. in_kind 0 appends
//   in_ch to the first string, 1 to the second, 2 ends the pair; 3 is ignored.
//   characters past MAX_LEN are dropped and flagged with out_too_long.
// output: one beat per end item, out_valid high for exactly one cycle with
//   out_distance (saturated at 127) and out_too_long; it cannot be held off.
// character beats leave busy low.
// an end beat with an empty string answers in the next cycle. otherwise busy is
//   high through a seed step, which loads the row of cells, a feed step, which
//   feeds the first string's characters from its memory into the chain, and a
//   drain step, in which the last row ripples out to column m (m the second
//   string's length); the result beat is on the ports in the first cycle busy
//   is low, when the next beat may already be taken. both strings are cleared
//   when the result is sent.
// reset clears lengths, flag and control; the character stores need no clear.
module osa_edit_distance_top #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  output logic [6:0] out_distance,
  output logic       out_too_long
);
  import osa_pkg::*;

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW = LW;
  localparam int SW = (LW + 1 > DIST_OUT_W) ? LW + 1 : DIST_OUT_W;

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_FEED, S_DRAIN} state_t;

  state_t          state_r, state_nxt;
  logic [LW-1:0]   first_len_r, first_len_nxt;
  logic [LW-1:0]   second_len_r, second_len_nxt;
  logic            ovf_r, ovf_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic [7:0]      a_prev_r, a_prev_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [6:0]      out_distance_r, out_distance_nxt;
  logic            out_too_long_r, out_too_long_nxt;

  logic [7:0]      first_mem [MAX_LEN];
  logic [7:0]      rd_data_r;
  logic [AW-1:0]   rd_addr;

  logic            accept;
  logic            first_wr, second_wr;
  logic [LW-1:0]   cnt_inc, last_col;
  link_ctl_t       src_ctl;
  logic [MAX_LEN-1:0][DW-1:0] col_d;

  function automatic logic [6:0] sat(input logic [SW-1:0] x);
    return (x > SW'(DIST_SAT)) ? DIST_SAT : x[6:0];
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign first_wr  = accept && (in_kind == KIND_FIRST) && (first_len_r < LW'(MAX_LEN));
  assign second_wr = accept && (in_kind == KIND_SECOND) && (second_len_r < LW'(MAX_LEN));
  assign cnt_inc   = cnt_r + LW'(1);
  assign last_col  = second_len_r - LW'(1);

  always_comb begin
    rd_addr = '0;
    if (state_r == S_FEED && cnt_inc < first_len_r) rd_addr = cnt_inc[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (first_wr) first_mem[first_len_r[AW-1:0]] <= fold(in_ch);
    rd_data_r <= first_mem[rd_addr];
  end

  // row i = cnt + 1 enters column one
  always_comb begin
    src_ctl.valid     = (state_r == S_FEED);
    src_ctl.later_row = (cnt_r != '0);
  end

  osa_chain #(.MAX_LEN(MAX_LEN), .DW(DW), .AW(AW)) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .init   (state_r == S_INIT),
    .wr_en  (second_wr),
    .wr_idx (second_len_r[AW-1:0]),
    .wr_char(fold(in_ch)),
    .src_ctl(src_ctl),
    .src_a  (rd_data_r),
    .src_a1 (a_prev_r),
    .src_d  (cnt_inc),
    .src_d1 (cnt_r),
    .col_d  (col_d)
  );

  always_comb begin
    state_nxt        = state_r;
    first_len_nxt    = first_len_r;
    second_len_nxt   = second_len_r;
    ovf_nxt          = ovf_r;
    cnt_nxt          = cnt_r;
    a_prev_nxt       = a_prev_r;
    out_valid_nxt    = 1'b0;
    out_distance_nxt = out_distance_r;
    out_too_long_nxt = out_too_long_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_FIRST: begin
              if (first_wr) first_len_nxt = first_len_r + LW'(1);
              else ovf_nxt = 1'b1;
            end
            KIND_SECOND: begin
              if (second_wr) second_len_nxt = second_len_r + LW'(1);
              else ovf_nxt = 1'b1;
            end
            KIND_END: begin
              if (first_len_r == '0 || second_len_r == '0) begin
                out_valid_nxt    = 1'b1;
                out_distance_nxt = sat(SW'(first_len_r) + SW'(second_len_r));
                out_too_long_nxt = ovf_r;
                first_len_nxt    = '0;
                second_len_nxt   = '0;
                ovf_nxt          = 1'b0;
              end else begin
                state_nxt = S_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        state_nxt = S_FEED;
        cnt_nxt   = '0;
      end
      S_FEED: begin
        a_prev_nxt = rd_data_r;
        if (cnt_inc == first_len_r) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      S_DRAIN: begin
        // last row has reached column m
        if (cnt_r == last_col) begin
          state_nxt        = S_IDLE;
          out_valid_nxt    = 1'b1;
          out_distance_nxt = sat(SW'(col_d[last_col[AW-1:0]]));
          out_too_long_nxt = ovf_r;
          first_len_nxt    = '0;
          second_len_nxt   = '0;
          ovf_nxt          = 1'b0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      first_len_r    <= '0;
      second_len_r   <= '0;
      ovf_r          <= 1'b0;
      cnt_r          <= '0;
      a_prev_r       <= '0;
      out_valid_r    <= 1'b0;
      out_distance_r <= '0;
      out_too_long_r <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      first_len_r    <= first_len_nxt;
      second_len_r   <= second_len_nxt;
      ovf_r          <= ovf_nxt;
      cnt_r          <= cnt_nxt;
      a_prev_r       <= a_prev_nxt;
      out_valid_r    <= out_valid_nxt;
      out_distance_r <= out_distance_nxt;
      out_too_long_r <= out_too_long_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_too_long = out_too_long_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    first_len_r <= LW'(MAX_LEN) && second_len_r <= LW'(MAX_LEN))
    else $error("string length beyond MAX_LEN");

  a_sweep_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (first_len_r != '0 && second_len_r != '0))
    else $error("sweep running on an empty string");

  a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (first_len_r == '0 && second_len_r == '0 && !ovf_r))
    else $error("strings not cleared with the result beat");

  a_drain_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && cnt_r == last_col) |=> (out_valid && !busy))
    else $error("drain finished without a result beat");

endmodule

// File: design/osa_cell.sv
`timescale 1ns / 1ps

module osa_cell #(
  parameter int DW = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     init,
  input  logic [DW-1:0]            col,
  input  logic                     is_first,
  input  logic                     wr,
  input  logic [7:0]               wr_char,
  input  logic [7:0]               left_b,
  input  osa_pkg::link_ctl_t       in_ctl,
  input  logic [7:0]               in_a,
  input  logic [7:0]               in_a1,
  input  logic [DW-1:0]            in_d,
  input  logic [DW-1:0]            in_d1,
  input  logic [DW-1:0]            in_g1,
  output osa_pkg::link_ctl_t       out_ctl,
  output logic [7:0]               out_a,
  output logic [7:0]               out_a1,
  output logic [DW-1:0]            out_d,
  output logic [DW-1:0]            out_d1,
  output logic [DW-1:0]            out_g1,
  output logic [7:0]               out_b
);
  import osa_pkg::*;

  link_ctl_t     ctl_r;
  logic [7:0]    a_r, a1_r, b_r;
  logic [DW-1:0] d_r, d1_r, g_r, g1_r;

  logic [DW:0] up1, left1, diag, swp, m1, m2, v;
  logic        can_swap;

  always_comb begin
    up1   = {1'b0, d_r} + 1'b1;
    left1 = {1'b0, in_d} + 1'b1;
    diag  = {1'b0, in_d1} + {{DW{1'b0}}, (in_a != b_r)};
    swp   = {1'b0, in_g1} + 1'b1;
    // adjacent swap: a_i == b_(j-1) and a_(i-1) == b_j
    can_swap = in_ctl.later_row && !is_first && (in_a == left_b) && (in_a1 == b_r);
    m1 = (up1 < left1) ? up1 : left1;
    m2 = (diag < m1) ? diag : m1;
    v  = (can_swap && swp < m2) ? swp : m2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (init) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) b_r <= wr_char;
    if (init) begin
      d_r <= col;
    end else if (in_ctl.valid) begin
      a_r  <= in_a;
      a1_r <= in_a1;
      d1_r <= d_r;
      d_r  <= v[DW-1:0];
      g_r  <= in_d1;
      g1_r <= g_r;
    end
  end

  assign out_ctl = ctl_r;
  assign out_a   = a_r;
  assign out_a1  = a1_r;
  assign out_d   = d_r;
  assign out_d1  = d1_r;
  assign out_g1  = g1_r;
  assign out_b   = b_r;

endmodule

// File: design/osa_chain.sv
`timescale 1ns / 1ps

module osa_chain #(
  parameter int MAX_LEN = 64,
  parameter int DW      = 7,
  parameter int AW      = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          init,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_idx,
  input  logic [7:0]                    wr_char,
  input  osa_pkg::link_ctl_t            src_ctl,
  input  logic [7:0]                    src_a,
  input  logic [7:0]                    src_a1,
  input  logic [DW-1:0]                 src_d,
  input  logic [DW-1:0]                 src_d1,
  output logic [MAX_LEN-1:0][DW-1:0]    col_d
);
  import osa_pkg::*;

  link_ctl_t     ctl_l [MAX_LEN+1];
  logic [7:0]    a_l   [MAX_LEN+1];
  logic [7:0]    a1_l  [MAX_LEN+1];
  logic [7:0]    b_l   [MAX_LEN+1];
  logic [DW-1:0] d_l   [MAX_LEN+1];
  logic [DW-1:0] d1_l  [MAX_LEN+1];
  logic [DW-1:0] g1_l  [MAX_LEN+1];

  // left boundary: column zero of the distance table
  assign ctl_l[0] = src_ctl;
  assign a_l[0]   = src_a;
  assign a1_l[0]  = src_a1;
  assign b_l[0]   = '0;
  assign d_l[0]   = src_d;
  assign d1_l[0]  = src_d1;
  assign g1_l[0]  = '0;

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    osa_cell #(.DW(DW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .init    (init),
      .col     (DW'(j + 1)),
      .is_first(j == 0),
      .wr      (wr_en && (wr_idx == AW'(j))),
      .wr_char (wr_char),
      .left_b  (b_l[j]),
      .in_ctl  (ctl_l[j]),
      .in_a    (a_l[j]),
      .in_a1   (a1_l[j]),
      .in_d    (d_l[j]),
      .in_d1   (d1_l[j]),
      .in_g1   (g1_l[j]),
      .out_ctl (ctl_l[j+1]),
      .out_a   (a_l[j+1]),
      .out_a1  (a1_l[j+1]),
      .out_d   (d_l[j+1]),
      .out_d1  (d1_l[j+1]),
      .out_g1  (g1_l[j+1]),
      .out_b   (b_l[j+1])
    );
    assign col_d[j] = d_l[j+1];
  end

endmodule
